/* rtl/core/vor_pkg.sv */
// ----------------------------------------------------------------------------
// vor_pkg
// Shared types, constants and projection helpers of the voxel rasterizer.
// ----------------------------------------------------------------------------
package vor_pkg;

   localparam int MAX_CELLS  = 4096;
   localparam int CELL_AW    = 12;
   localparam int CNT_W      = 13;
   localparam int GRID_W     = 64;
   localparam int GRID_H     = 64;
   localparam int GRID_CELLS = GRID_W * GRID_H;
   localparam int GRID_AW    = 12;
   localparam int DIM_LIMIT  = 1024;
   localparam int COORD_BITS = 16;
   localparam int PROJ_W     = COORD_BITS + 1;
   localparam int CELL_DW    = 3 * COORD_BITS + 24;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_FINISH = 2'd1,
      CMD_PULL   = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_CELLS  = 3'd1;
   localparam logic [2:0] ST_PIX_LIMIT = 3'd2;
   localparam logic [2:0] ST_GRID_SMALL = 3'd3;
   localparam logic [2:0] ST_LIST_FULL = 3'd4;
   localparam logic [2:0] ST_NO_IMAGE  = 3'd5;

   localparam logic [1:0] MODE_NEAREST    = 2'd0;
   localparam logic [1:0] MODE_SILHOUETTE = 2'd1;
   localparam logic [1:0] MODE_THICKNESS  = 2'd2;

   localparam logic [2:0] AXIS_PX = 3'd0;
   localparam logic [2:0] AXIS_PZ = 3'd4;
   localparam logic [2:0] AXIS_NZ = 3'd5;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [23:0]        cell_rgb;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [10:0] image_width;
      logic [10:0] image_height;
      logic [31:0] pixel;
      logic        last;
   } rsp_type;

   typedef struct packed {
      cmd_type            kind;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [23:0]        cell_rgb;
   } item_type;

   typedef struct packed {
      logic [1:0]  raster_mode;
      logic [2:0]  forward_axis;
      logic [2:0]  up_axis;
      logic [4:0]  pixels_per_cell;
      logic [24:0] max_pixels;
      logic [31:0] background_color;
      logic [31:0] foreground_color;
   } cfg_type;

   function automatic logic [2:0] axis_fix(input logic [2:0] code);
      axis_fix = (code > AXIS_NZ) ? AXIS_PX : code;
   endfunction

   // right = up x forward, both unit axes on different world axes
   function automatic logic [2:0] right_code(input logic [2:0] uc, input logic [2:0] fc);
      logic [1:0] k;
      logic       cyc;
      k   = 2'd3 - uc[2:1] - fc[2:1];
      cyc = (uc[2:1] == 2'd0 && fc[2:1] == 2'd1) || (uc[2:1] == 2'd1 && fc[2:1] == 2'd2) ||
            (uc[2:1] == 2'd2 && fc[2:1] == 2'd0);
      right_code = {k, uc[0] ^ fc[0] ^ ~cyc};
   endfunction

   function automatic logic signed [PROJ_W-1:0] proj(input logic signed [15:0] x,
      input logic signed [15:0] y, input logic signed [15:0] z, input logic [2:0] code);
      logic signed [PROJ_W-1:0] v;
      case (code[2:1])
         2'd0: v = {x[15], x};
         2'd1: v = {y[15], y};
         default: v = {z[15], z};
      endcase
      proj = code[0] ? -v : v;
   endfunction

endpackage

/* rtl/core/vor_ram.sv */
// ----------------------------------------------------------------------------
// vor_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module vor_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* rtl/core/vor_front.sv */
// ----------------------------------------------------------------------------
// vor_front
// Request intake: classifies commands, drops unknown ones, queues the rest.
// ----------------------------------------------------------------------------
module vor_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  vor_pkg::req_type  req_data,
   output logic              item_valid,
   output vor_pkg::item_type item,
   input  logic              take
);
   import vor_pkg::*;

   localparam int QD  = 4;
   localparam int QAW = 2;

   item_type       q_ff [QD];
   logic [QAW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QAW:0]   cnt_ff, cnt_in;
   logic           enq, deq;
   item_type       new_item;

   assign req_full   = (cnt_ff == (QAW+1)'(QD));
   assign enq        = req_push && !req_full && (req_data.cmd != CMD_NONE);
   assign deq        = take && (cnt_ff != '0);
   assign item_valid = (cnt_ff != '0);
   assign item       = q_ff[head_ff];

   always_comb begin
      new_item.kind     = cmd_type'(req_data.cmd);
      new_item.pos_x    = req_data.pos_x;
      new_item.pos_y    = req_data.pos_y;
      new_item.pos_z    = req_data.pos_z;
      new_item.cell_rgb = req_data.cell_rgb;
      head_in = deq ? head_ff + QAW'(1) : head_ff;
      tail_in = enq ? tail_ff + QAW'(1) : tail_ff;
      cnt_in  = cnt_ff + (QAW+1)'(enq) - (QAW+1)'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[tail_ff] <= new_item;
      end
   end
endmodule

/* rtl/core/vor_back.sv */
// ----------------------------------------------------------------------------
// vor_back
// Command engine: stores cells, runs the finish passes over cell list and
// grid, serves pixel reads, and buffers results in a two-entry queue.
// ----------------------------------------------------------------------------
module vor_back (
   input  logic              clock,
   input  logic              reset,
   input  vor_pkg::cfg_type  cfg,
   input  logic              item_valid,
   input  vor_pkg::item_type item,
   output logic              take,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output vor_pkg::rsp_type  rsp_data
);
   import vor_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_PULL, S_BND, S_CW, S_WH, S_PROD, S_CHECK, S_CLR,
      S_SC_RD, S_SC_IDX, S_SC_GRD, S_SC_UPD, S_MAX, S_NR_RD, S_NR_LD, S_NR_DIV, S_DONE
   } state_type;

   localparam logic signed [PROJ_W-1:0] PROJ_TOP = {1'b0, {(PROJ_W-1){1'b1}}};
   localparam logic signed [PROJ_W-1:0] PROJ_BOT = {1'b1, {(PROJ_W-1){1'b0}}};

   state_type state_ff, state_in;
   logic [CNT_W-1:0] total_ff, total_in, n_ff, n_in, cnt_ff, cnt_in;
   logic vld_ff, vld_in;
   logic [2:0] fc_ff, fc_in, yc_ff, yc_in, rc_ff, rc_in;
   logic [1:0] mode_ff, mode_in;
   logic signed [PROJ_W-1:0] minx_ff, minx_in, miny_ff, miny_in, maxx_ff, maxx_in;
   logic signed [PROJ_W-1:0] maxy_ff, maxy_in, dep_ff, dep_in;
   logic [17:0] cw_ff, cw_in, ch_ff, ch_in;
   logic [22:0] w_ff, w_in, h_ff, h_in;
   logic too_big_ff, too_big_in;
   logic [21:0] prod_ff, prod_in, rem_ff, rem_in;
   logic [5:0] xo_ff, xo_in, yo_ff, yo_in;
   logic [23:0] col_ff, col_in;
   logic [GRID_AW-1:0] gidx_ff, gidx_in, rowbase_ff, rowbase_in;
   logic [CNT_W-1:0] mx_ff, mx_in;
   logic [13:0] den_ff, den_in;
   logic [2:0] qbit_ff, qbit_in;
   logic [7:0] quo_ff, quo_in;
   logic img_ready_ff, img_ready_in;
   logic [10:0] img_w_ff, img_w_in, img_h_ff, img_h_in, px_ff, px_in, py_ff, py_in;
   logic [6:0] img_cw_ff, img_cw_in;
   logic [4:0] img_scale_ff, img_scale_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [5:0] cx_ff, cx_in;

   // memories
   logic cell_we;
   logic [CELL_AW-1:0] cell_raddr;
   logic [CELL_DW-1:0] cell_wdata, cell_rdata;
   logic color_we, depth_we, count_we;
   logic [GRID_AW-1:0] grid_raddr;
   logic [31:0] color_wdata, color_rdata;
   logic [PROJ_W-1:0] depth_wdata, depth_rdata;
   logic [CNT_W-1:0] count_wdata, count_rdata;

   // result queue
   rsp_type ob_ff [2];
   logic ob_head_ff, ob_head_in, ob_tail_ff, ob_tail_in;
   logic [1:0] ob_cnt_ff, ob_cnt_in;
   logic push_rsp, pop_rsp;
   rsp_type rsp_new;

   // combinational helpers
   logic signed [15:0] cd_x, cd_y, cd_z;
   logic signed [PROJ_W-1:0] pj_x, pj_y, pj_d;
   logic [2:0] fc_c, uc0_c, uc_c;
   logic [4:0] scale_c;
   logic [GRID_AW-1:0] sc_idx;
   logic [21:0] trial;
   logic [7:0] quo_c, lv;
   logic [21:0] rem_c;

   assign cd_x = cell_rdata[CELL_DW-1 -: 16];
   assign cd_y = cell_rdata[CELL_DW-17 -: 16];
   assign cd_z = cell_rdata[CELL_DW-33 -: 16];
   assign pj_x = proj(cd_x, cd_y, cd_z, rc_ff);
   assign pj_y = proj(cd_x, cd_y, cd_z, yc_ff);
   assign pj_d = proj(cd_x, cd_y, cd_z, fc_ff);

   assign fc_c  = axis_fix(cfg.forward_axis);
   assign uc0_c = axis_fix(cfg.up_axis);
   assign uc_c  = (uc0_c[2:1] == fc_c[2:1]) ? ((fc_c[2:1] == 2'd2) ? AXIS_PX : AXIS_PZ) : uc0_c;
   assign scale_c = (cfg.pixels_per_cell == 5'd0) ? 5'd1 :
                    (cfg.pixels_per_cell > 5'd16) ? 5'd16 : cfg.pixels_per_cell;
   assign sc_idx = GRID_AW'(13'(yo_ff * cw_ff[6:0]) + 13'(xo_ff));
   assign trial  = 22'(den_ff) << qbit_ff;

   always_comb begin
      rem_c = rem_ff;
      quo_c = quo_ff;
      if (rem_ff >= trial) begin
         rem_c = rem_ff - trial;
         quo_c[qbit_ff] = 1'b1;
      end
      lv = (quo_c == 8'd0) ? 8'd1 : quo_c;
   end

   assign cell_wdata = {item.pos_x, item.pos_y, item.pos_z, item.cell_rgb};

   always_comb begin
      state_in = state_ff; total_in = total_ff; n_in = n_ff; cnt_in = cnt_ff; vld_in = vld_ff;
      fc_in = fc_ff; yc_in = yc_ff; rc_in = rc_ff; mode_in = mode_ff;
      minx_in = minx_ff; miny_in = miny_ff; maxx_in = maxx_ff; maxy_in = maxy_ff;
      dep_in = dep_ff; cw_in = cw_ff; ch_in = ch_ff; w_in = w_ff; h_in = h_ff;
      too_big_in = too_big_ff; prod_in = prod_ff; rem_in = rem_ff; xo_in = xo_ff; yo_in = yo_ff;
      col_in = col_ff; gidx_in = gidx_ff; rowbase_in = rowbase_ff; mx_in = mx_ff;
      den_in = den_ff; qbit_in = qbit_ff; quo_in = quo_ff; img_ready_in = img_ready_ff;
      img_w_in = img_w_ff; img_h_in = img_h_ff; img_cw_in = img_cw_ff;
      img_scale_in = img_scale_ff; px_in = px_ff; py_in = py_ff; sx_in = sx_ff; sy_in = sy_ff;
      cx_in = cx_ff;
      take = 1'b0; cell_we = 1'b0; cell_raddr = cnt_ff[CELL_AW-1:0];
      grid_raddr = gidx_ff; color_we = 1'b0; depth_we = 1'b0; count_we = 1'b0;
      color_wdata = cfg.background_color; depth_wdata = PROJ_TOP; count_wdata = '0;
      push_rsp = 1'b0; rsp_new = '0;
      case (state_ff)
         S_IDLE: begin
            if (item_valid && ob_cnt_ff != 2'd2) begin
               take = 1'b1;
               case (item.kind)
                  CMD_ADD: begin
                     if (total_ff == CNT_W'(MAX_CELLS)) begin
                        push_rsp = 1'b1;
                        rsp_new.status = ST_LIST_FULL;
                     end else begin
                        cell_we  = 1'b1;
                        total_in = total_ff + CNT_W'(1);
                     end
                  end
                  CMD_FINISH: begin
                     img_ready_in = 1'b0;
                     px_in = '0; py_in = '0; sx_in = '0; sy_in = '0; cx_in = '0; rowbase_in = '0;
                     total_in = '0;
                     n_in = total_ff;
                     if (total_ff == '0) begin
                        push_rsp = 1'b1;
                        rsp_new.status = ST_NO_CELLS;
                     end else begin
                        fc_in = fc_c;
                        yc_in = uc_c ^ 3'd1;   // down is minus up
                        rc_in = right_code(uc_c, fc_c);
                        mode_in = (cfg.raster_mode == MODE_THICKNESS) ? MODE_THICKNESS :
                                  (cfg.raster_mode == MODE_SILHOUETTE) ? MODE_SILHOUETTE :
                                  MODE_NEAREST;
                        minx_in = PROJ_TOP; miny_in = PROJ_TOP;
                        maxx_in = PROJ_BOT; maxy_in = PROJ_BOT;
                        cnt_in = '0; vld_in = 1'b0;
                        state_in = S_BND;
                     end
                  end
                  CMD_PULL: begin
                     if (!img_ready_ff) begin
                        push_rsp = 1'b1;
                        rsp_new.status = ST_NO_IMAGE;
                     end else begin
                        grid_raddr = rowbase_ff + GRID_AW'(cx_ff);
                        state_in = S_PULL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PULL: begin
            push_rsp = 1'b1;
            rsp_new.status = ST_OK;
            rsp_new.image_width = img_w_ff;
            rsp_new.image_height = img_h_ff;
            rsp_new.pixel = color_rdata;
            rsp_new.last = (px_ff == img_w_ff - 11'd1) && (py_ff == img_h_ff - 11'd1);
            if (px_ff == img_w_ff - 11'd1) begin
               px_in = '0; sx_in = '0; cx_in = '0;
               if (py_ff == img_h_ff - 11'd1) begin
                  py_in = '0; sy_in = '0; rowbase_in = '0;
               end else begin
                  py_in = py_ff + 11'd1;
                  if (sy_ff == img_scale_ff - 5'd1) begin
                     sy_in = '0;
                     rowbase_in = rowbase_ff + GRID_AW'(img_cw_ff);
                  end else begin
                     sy_in = sy_ff + 5'd1;
                  end
               end
            end else begin
               px_in = px_ff + 11'd1;
               if (sx_ff == img_scale_ff - 5'd1) begin
                  sx_in = '0;
                  cx_in = cx_ff + 6'd1;
               end else begin
                  sx_in = sx_ff + 5'd1;
               end
            end
            state_in = S_IDLE;
         end
         S_BND: begin
            // issue one cell read a cycle, fold the previous one into the bounds
            vld_in = (cnt_ff != n_ff);
            if (cnt_ff != n_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (vld_ff) begin
               if (pj_x < minx_ff) minx_in = pj_x;
               if (pj_x > maxx_ff) maxx_in = pj_x;
               if (pj_y < miny_ff) miny_in = pj_y;
               if (pj_y > maxy_ff) maxy_in = pj_y;
            end
            if (cnt_ff == n_ff && !vld_ff) begin
               state_in = S_CW;
            end
         end
         S_CW: begin
            cw_in = 18'({maxx_ff[PROJ_W-1], maxx_ff} - {minx_ff[PROJ_W-1], minx_ff} + 18'd1);
            ch_in = 18'({maxy_ff[PROJ_W-1], maxy_ff} - {miny_ff[PROJ_W-1], miny_ff} + 18'd1);
            state_in = S_WH;
         end
         S_WH: begin
            w_in = cw_ff * scale_c;
            h_in = ch_ff * scale_c;
            img_scale_in = scale_c;
            state_in = S_PROD;
         end
         S_PROD: begin
            too_big_in = (w_ff > 23'(DIM_LIMIT)) || (h_ff > 23'(DIM_LIMIT));
            prod_in = w_ff[10:0] * h_ff[10:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (too_big_ff || {3'b000, prod_ff} > cfg.max_pixels) begin
               push_rsp = 1'b1;
               rsp_new.status = ST_PIX_LIMIT;
               state_in = S_IDLE;
            end else if (cw_ff > 18'(GRID_W) || ch_ff > 18'(GRID_H)) begin
               push_rsp = 1'b1;
               rsp_new.status = ST_GRID_SMALL;
               state_in = S_IDLE;
            end else begin
               gidx_in = '0;
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            color_we = 1'b1; depth_we = 1'b1; count_we = 1'b1;
            gidx_in = gidx_ff + GRID_AW'(1);
            if (gidx_ff == '1) begin
               cnt_in = '0;
               state_in = S_SC_RD;
            end
         end
         S_SC_RD: begin
            if (cnt_ff == n_ff) begin
               if (mode_ff == MODE_THICKNESS) begin
                  cnt_in = '0; vld_in = 1'b0; mx_in = '0;
                  state_in = S_MAX;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               state_in = S_SC_IDX;
            end
         end
         S_SC_IDX: begin
            xo_in = 6'(pj_x - minx_ff);
            yo_in = 6'(pj_y - miny_ff);
            dep_in = pj_d;
            col_in = cell_rdata[23:0];
            state_in = S_SC_GRD;
         end
         S_SC_GRD: begin
            grid_raddr = sc_idx;
            gidx_in = sc_idx;
            state_in = S_SC_UPD;
         end
         S_SC_UPD: begin
            case (mode_ff)
               MODE_THICKNESS: begin
                  count_we = 1'b1;
                  count_wdata = count_rdata + CNT_W'(1);
               end
               MODE_SILHOUETTE: begin
                  color_we = 1'b1;
                  color_wdata = cfg.foreground_color;
               end
               default: begin
                  // strict less-than: first of equal depths stays
                  if (dep_ff < $signed(depth_rdata)) begin
                     depth_we = 1'b1;
                     depth_wdata = dep_ff;
                     color_we = 1'b1;
                     color_wdata = {col_ff, 8'hFF};
                  end
               end
            endcase
            state_in = S_SC_RD;
         end
         S_MAX: begin
            vld_in = (cnt_ff != CNT_W'(GRID_CELLS));
            if (cnt_ff != CNT_W'(GRID_CELLS)) begin
               grid_raddr = cnt_ff[GRID_AW-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (vld_ff && count_rdata > mx_ff) begin
               mx_in = count_rdata;
            end
            if (cnt_ff == CNT_W'(GRID_CELLS) && !vld_ff) begin
               gidx_in = '0;
               state_in = S_NR_RD;
            end
         end
         S_NR_RD: begin
            state_in = S_NR_LD;
         end
         S_NR_LD: begin
            if (count_rdata == '0) begin
               gidx_in = gidx_ff + GRID_AW'(1);
               state_in = (gidx_ff == '1) ? S_DONE : S_NR_RD;
            end else begin
               rem_in = 22'(count_rdata * 9'd510) + 22'(mx_ff);
               den_in = {mx_ff, 1'b0};
               qbit_in = 3'd7;
               quo_in = '0;
               state_in = S_NR_DIV;
            end
         end
         S_NR_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in = rem_c;
            quo_in = quo_c;
            qbit_in = qbit_ff - 3'd1;
            if (qbit_ff == 3'd0) begin
               color_we = 1'b1;
               color_wdata = {lv, lv, lv, 8'hFF};
               gidx_in = gidx_ff + GRID_AW'(1);
               state_in = (gidx_ff == '1) ? S_DONE : S_NR_RD;
            end
         end
         S_DONE: begin
            img_ready_in = 1'b1;
            img_w_in = w_ff[10:0];
            img_h_in = h_ff[10:0];
            img_cw_in = cw_ff[6:0];
            push_rsp = 1'b1;
            rsp_new.status = ST_OK;
            rsp_new.image_width = w_ff[10:0];
            rsp_new.image_height = h_ff[10:0];
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         img_ready_ff <= 1'b0;
         vld_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; sx_ff <= '0; sy_ff <= '0; cx_ff <= '0; rowbase_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         img_ready_ff <= img_ready_in;
         vld_ff <= vld_in;
         px_ff <= px_in; py_ff <= py_in; sx_ff <= sx_in; sy_ff <= sy_in; cx_ff <= cx_in;
         rowbase_ff <= rowbase_in;
      end
      n_ff <= n_in; cnt_ff <= cnt_in; fc_ff <= fc_in; yc_ff <= yc_in; rc_ff <= rc_in;
      mode_ff <= mode_in; minx_ff <= minx_in; miny_ff <= miny_in; maxx_ff <= maxx_in;
      maxy_ff <= maxy_in; dep_ff <= dep_in; cw_ff <= cw_in; ch_ff <= ch_in; w_ff <= w_in;
      h_ff <= h_in; too_big_ff <= too_big_in; prod_ff <= prod_in; rem_ff <= rem_in;
      xo_ff <= xo_in; yo_ff <= yo_in; col_ff <= col_in; gidx_ff <= gidx_in; mx_ff <= mx_in;
      den_ff <= den_in; qbit_ff <= qbit_in; quo_ff <= quo_in; img_w_ff <= img_w_in;
      img_h_ff <= img_h_in; img_cw_ff <= img_cw_in; img_scale_ff <= img_scale_in;
   end

   // result queue
   assign pop_rsp   = rsp_pop && (ob_cnt_ff != 2'd0);
   assign rsp_empty = (ob_cnt_ff == 2'd0);
   assign rsp_data  = ob_ff[ob_head_ff];

   always_comb begin
      ob_head_in = pop_rsp ? ~ob_head_ff : ob_head_ff;
      ob_tail_in = push_rsp ? ~ob_tail_ff : ob_tail_ff;
      ob_cnt_in  = ob_cnt_ff + 2'(push_rsp) - 2'(pop_rsp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ob_head_ff <= 1'b0;
         ob_tail_ff <= 1'b0;
         ob_cnt_ff  <= 2'd0;
      end else begin
         ob_head_ff <= ob_head_in;
         ob_tail_ff <= ob_tail_in;
         ob_cnt_ff  <= ob_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_rsp) begin
         ob_ff[ob_tail_ff] <= rsp_new;
      end
   end

   vor_ram #(.WIDTH(CELL_DW), .DEPTH(MAX_CELLS)) u_cell_ram (
      .clock(clock), .we(cell_we), .waddr(total_ff[CELL_AW-1:0]), .wdata(cell_wdata),
      .raddr(cell_raddr), .rdata(cell_rdata)
   );

   vor_ram #(.WIDTH(32), .DEPTH(GRID_CELLS)) u_color_ram (
      .clock(clock), .we(color_we), .waddr(gidx_ff), .wdata(color_wdata),
      .raddr(grid_raddr), .rdata(color_rdata)
   );

   vor_ram #(.WIDTH(PROJ_W), .DEPTH(GRID_CELLS)) u_depth_ram (
      .clock(clock), .we(depth_we), .waddr(gidx_ff), .wdata(depth_wdata),
      .raddr(grid_raddr), .rdata(depth_rdata)
   );

   vor_ram #(.WIDTH(CNT_W), .DEPTH(GRID_CELLS)) u_count_ram (
      .clock(clock), .we(count_we), .waddr(gidx_ff), .wdata(count_wdata),
      .raddr(grid_raddr), .rdata(count_rdata)
   );

   a_ob_bound: assert property (@(posedge clock) disable iff (reset) ob_cnt_ff != 2'd3)
      else $error("result queue overflow");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push_rsp |-> (ob_cnt_ff != 2'd2) || pop_rsp)
      else $error("result pushed into full queue");
   a_pull_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PULL |-> img_ready_ff)
      else $error("pixel read without image");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NR_DIV |-> den_ff != '0)
      else $error("thickness divide by zero");
endmodule

/* rtl/core/voxel_orthographic_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// voxel_orthographic_rasterizer_unit
// Orthographic z-buffer voxel rasterizer with a register port and queues.
// ----------------------------------------------------------------------------
// add stores one cell; pull reads the grid color memory; one request at a time
// finish with n cells: a bounds pass over the cells, grid clear and scatter;
//   thickness mode adds a max sweep and a divider pass per covered grid cell
// results wait in a two-entry queue, requests in a four-entry queue
// reset (synchronous): empties queues and cell list, no image ready;
//   configuration registers return to their defaults, memories are not cleared
module voxel_orthographic_rasterizer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  vor_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output vor_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import vor_pkg::*;

   localparam logic [2:0] REG_MODE  = 3'd0;
   localparam logic [2:0] REG_FWD   = 3'd1;
   localparam logic [2:0] REG_UP    = 3'd2;
   localparam logic [2:0] REG_PPC   = 3'd3;
   localparam logic [2:0] REG_MAXPX = 3'd4;
   localparam logic [2:0] REG_BG    = 3'd5;
   localparam logic [2:0] REG_FG    = 3'd6;

   cfg_type  cfg_ff, cfg_in;
   logic     wr;
   logic     item_valid, take;
   item_type item;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[4:2])
            REG_MODE:  cfg_in.raster_mode      = csr_pwdata[1:0];
            REG_FWD:   cfg_in.forward_axis     = csr_pwdata[2:0];
            REG_UP:    cfg_in.up_axis          = csr_pwdata[2:0];
            REG_PPC:   cfg_in.pixels_per_cell  = csr_pwdata[4:0];
            REG_MAXPX: cfg_in.max_pixels       = csr_pwdata[24:0];
            REG_BG:    cfg_in.background_color = csr_pwdata;
            REG_FG:    cfg_in.foreground_color = csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_MODE:  csr_prdata = {30'd0, cfg_ff.raster_mode};
         REG_FWD:   csr_prdata = {29'd0, cfg_ff.forward_axis};
         REG_UP:    csr_prdata = {29'd0, cfg_ff.up_axis};
         REG_PPC:   csr_prdata = {27'd0, cfg_ff.pixels_per_cell};
         REG_MAXPX: csr_prdata = {7'd0, cfg_ff.max_pixels};
         REG_BG:    csr_prdata = cfg_ff.background_color;
         REG_FG:    csr_prdata = cfg_ff.foreground_color;
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.raster_mode      <= MODE_NEAREST;
         cfg_ff.forward_axis     <= AXIS_PX;
         cfg_ff.up_axis          <= AXIS_PZ;
         cfg_ff.pixels_per_cell  <= 5'd1;
         cfg_ff.max_pixels       <= 25'd1048576;
         cfg_ff.background_color <= 32'h0000_0000;
         cfg_ff.foreground_color <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   vor_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .item_valid(item_valid), .item(item), .take(take)
   );

   vor_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .item_valid(item_valid), .item(item),
      .take(take), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );
endmodule

/* tb/vor_csr_pkg.sv */
// ----------------------------------------------------------------------------
// vor_csr_pkg
// Register indexes of the rasterizer register port, shared by the testbench.
// ----------------------------------------------------------------------------
package vor_csr_pkg;

   typedef enum logic [2:0] {
      REG_RASTER_MODE  = 3'd0,
      REG_FORWARD_AXIS = 3'd1,
      REG_UP_AXIS      = 3'd2,
      REG_PIX_PER_CELL = 3'd3,
      REG_MAX_PIXELS   = 3'd4,
      REG_BACKGROUND   = 3'd5,
      REG_FOREGROUND   = 3'd6
   } reg_index;

endpackage

/* tb/vor_checker.sv */
// ----------------------------------------------------------------------------
// vor_checker
// Watches the request, response and register ports of the rasterizer, keeps
// its own copy of the cell list, grid and image, and compares every response.
// ----------------------------------------------------------------------------
module vor_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  vor_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  vor_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               outstanding,
   output int               failures
);
   import vor_pkg::*;
   import vor_csr_pkg::*;

   logic [1:0]  mode;
   logic [2:0]  fwd_code;
   logic [2:0]  up_code;
   logic [4:0]  ppc;
   logic [24:0] max_pix;
   logic [31:0] bg_color;
   logic [31:0] fg_color;

   int          cell_x [MAX_CELLS];
   int          cell_y [MAX_CELLS];
   int          cell_z [MAX_CELLS];
   logic [23:0] cell_rgb [MAX_CELLS];
   int          n_cells;

   logic [31:0] grid_col [GRID_CELLS];
   int          grid_dep [GRID_CELLS];
   int          grid_cnt [GRID_CELLS];
   bit          img_ready;
   int          img_w, img_h, img_cw, img_scale, cursor;

   rsp_type     pending_rsp [$];

   initial failures = 0;

   function automatic int axis_comp(input logic [2:0] code, input int k);
      logic [2:0] c;
      c = (code > 3'd5) ? AXIS_PX : code;
      if (c[2:1] != k) return 0;
      return c[0] ? -1 : 1;
   endfunction

   function automatic logic [2:0] rasterize();
      logic [2:0] fc, uc;
      int f0, f1, f2, u0, u1, u2, r0, r1, r2;
      int n, i, px, py, d, idx, min_r, min_d, max_r, max_d, mx, scale;
      longint cw, ch, w, h, lv;
      img_ready = 0;
      cursor = 0;
      n = n_cells;
      n_cells = 0;
      if (n == 0) return ST_NO_CELLS;
      fc = (fwd_code > 3'd5) ? AXIS_PX : fwd_code;
      uc = (up_code > 3'd5) ? AXIS_PX : up_code;
      // up along the view axis falls back to a fixed axis
      if (uc[2:1] == fc[2:1]) uc = (fc[2:1] == 2'd2) ? AXIS_PX : AXIS_PZ;
      f0 = axis_comp(fc, 0); f1 = axis_comp(fc, 1); f2 = axis_comp(fc, 2);
      u0 = axis_comp(uc, 0); u1 = axis_comp(uc, 1); u2 = axis_comp(uc, 2);
      r0 = u1 * f2 - u2 * f1;
      r1 = u2 * f0 - u0 * f2;
      r2 = u0 * f1 - u1 * f0;
      min_r = 32'h7fffffff; min_d = 32'h7fffffff;
      max_r = 32'h80000000; max_d = 32'h80000000;
      for (i = 0; i < n; i++) begin
         px = cell_x[i] * r0 + cell_y[i] * r1 + cell_z[i] * r2;
         py = -(cell_x[i] * u0 + cell_y[i] * u1 + cell_z[i] * u2);
         if (px < min_r) min_r = px;
         if (py < min_d) min_d = py;
         if (px > max_r) max_r = px;
         if (py > max_d) max_d = py;
      end
      scale = (ppc == 0) ? 1 : ((ppc > 16) ? 16 : ppc);
      cw = longint'(max_r) - min_r + 1;
      ch = longint'(max_d) - min_d + 1;
      w = cw * scale;
      h = ch * scale;
      if (w * h > longint'(max_pix) || w > DIM_LIMIT || h > DIM_LIMIT) return ST_PIX_LIMIT;
      if (cw > GRID_W || ch > GRID_H) return ST_GRID_SMALL;
      for (i = 0; i < GRID_CELLS; i++) begin
         grid_col[i] = bg_color;
         grid_dep[i] = 32'h7fffffff;
         grid_cnt[i] = 0;
      end
      for (i = 0; i < n; i++) begin
         px = cell_x[i] * r0 + cell_y[i] * r1 + cell_z[i] * r2 - min_r;
         py = -(cell_x[i] * u0 + cell_y[i] * u1 + cell_z[i] * u2) - min_d;
         d = cell_x[i] * f0 + cell_y[i] * f1 + cell_z[i] * f2;
         idx = py * int'(cw) + px;
         if (idx < 0 || idx >= GRID_CELLS) continue;
         case (mode)
            MODE_THICKNESS: grid_cnt[idx]++;
            MODE_SILHOUETTE: grid_col[idx] = fg_color;
            default: begin
               // strict less-than keeps the first of equal depths
               if (d < grid_dep[idx]) begin
                  grid_dep[idx] = d;
                  grid_col[idx] = {cell_rgb[i], 8'hff};
               end
            end
         endcase
      end
      if (mode == MODE_THICKNESS) begin
         mx = 0;
         for (i = 0; i < GRID_CELLS; i++)
            if (grid_cnt[i] > mx) mx = grid_cnt[i];
         for (i = 0; i < GRID_CELLS; i++) begin
            if (grid_cnt[i] == 0 || mx == 0) continue;
            lv = (longint'(grid_cnt[i]) * 510 + mx) / (2 * longint'(mx));
            if (lv < 1) lv = 1;
            if (lv > 255) lv = 255;
            grid_col[i] = {lv[7:0], lv[7:0], lv[7:0], 8'hff};
         end
      end
      img_w = int'(w);
      img_h = int'(h);
      img_cw = int'(cw);
      img_scale = scale;
      img_ready = 1;
      return ST_OK;
   endfunction

   function automatic void predict(input req_type r);
      rsp_type e;
      int total, px, py, idx;
      e = '0;
      case (cmd_type'(r.cmd))
         CMD_ADD: begin
            if (n_cells >= MAX_CELLS) begin
               e.status = ST_LIST_FULL;
               pending_rsp.push_back(e);
            end else begin
               cell_x[n_cells] = r.pos_x;
               cell_y[n_cells] = r.pos_y;
               cell_z[n_cells] = r.pos_z;
               cell_rgb[n_cells] = r.cell_rgb;
               n_cells++;
            end
         end
         CMD_FINISH: begin
            e.status = rasterize();
            if (e.status == ST_OK) begin
               e.image_width = img_w[10:0];
               e.image_height = img_h[10:0];
            end
            pending_rsp.push_back(e);
         end
         CMD_PULL: begin
            if (!img_ready || img_w == 0) begin
               e.status = ST_NO_IMAGE;
            end else begin
               total = img_w * img_h;
               if (cursor >= total) cursor = 0;
               py = cursor / img_w;
               px = cursor % img_w;
               idx = (py / img_scale) * img_cw + px / img_scale;
               e.status = ST_OK;
               e.image_width = img_w[10:0];
               e.image_height = img_h[10:0];
               e.pixel = (idx < GRID_CELLS) ? grid_col[idx] : 32'h0;
               e.last = (cursor + 1 == total);
               cursor = e.last ? 0 : cursor + 1;
            end
            pending_rsp.push_back(e);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         mode = MODE_NEAREST;
         fwd_code = AXIS_PX;
         up_code = AXIS_PZ;
         ppc = 5'd1;
         max_pix = 25'd1048576;
         bg_color = 32'h0;
         fg_color = 32'hffffffff;
         n_cells = 0;
         img_ready = 0;
         cursor = 0;
         pending_rsp.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
               failures++;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_data.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_data.status);
                  failures++;
               end
               if (rsp_data.image_width !== e.image_width) begin
                  $display("%0t: image_width expected %0d actual %0d", $time,
                           e.image_width, rsp_data.image_width);
                  failures++;
               end
               if (rsp_data.image_height !== e.image_height) begin
                  $display("%0t: image_height expected %0d actual %0d", $time,
                           e.image_height, rsp_data.image_height);
                  failures++;
               end
               if (rsp_data.pixel !== e.pixel) begin
                  $display("%0t: pixel expected %h actual %h", $time, e.pixel, rsp_data.pixel);
                  failures++;
               end
               if (rsp_data.last !== e.last) begin
                  $display("%0t: last expected %b actual %b", $time, e.last, rsp_data.last);
                  failures++;
               end
            end
         end
         if (req_push && !req_full) predict(req_data);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index'(csr_paddr[4:2]))
               REG_RASTER_MODE:  mode = csr_pwdata[1:0];
               REG_FORWARD_AXIS: fwd_code = csr_pwdata[2:0];
               REG_UP_AXIS:      up_code = csr_pwdata[2:0];
               REG_PIX_PER_CELL: ppc = csr_pwdata[4:0];
               REG_MAX_PIXELS:   max_pix = csr_pwdata[24:0];
               REG_BACKGROUND:   bg_color = csr_pwdata;
               REG_FOREGROUND:   fg_color = csr_pwdata;
               default: ;
            endcase
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

/* tb/voxel_orthographic_rasterizer_unit_tb.sv */
// ----------------------------------------------------------------------------
// voxel_orthographic_rasterizer_unit_tb
// Drives cell loads, finishes and pixel pulls with random idling and register
// changes between phases; a checker beside the block predicts every response.
// ----------------------------------------------------------------------------
module voxel_orthographic_rasterizer_unit_tb;
   import vor_pkg::*;
   import vor_csr_pkg::*;

   localparam int LIMIT = 40000000;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   req_type     req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          outstanding;
   int          failures;
   int          cycles;
   int          items;
   bit          calm;
   bit          hold_req;

   voxel_orthographic_rasterizer_unit uut (.*);

   vor_checker u_checker (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_data(req_data), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .outstanding(outstanding), .failures(failures)
   );

   initial begin
      clock = 0;
      reset = 1;
      req_push = 0;
      req_data = '0;
      rsp_pop = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycles = 0;
      items = 0;
      calm = 0;
      hold_req = 0;
   end

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // response side: random stalls, one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_pop <= 0;
            repeat (300) @(posedge clock);
            hold_req = 0;
            rsp_pop <= 1;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_pop <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_pop <= 1;
         end else begin
            rsp_pop <= 1;
         end
      end
   end

   task automatic send(input cmd_type c, input logic [15:0] x, input logic [15:0] y,
                       input logic [15:0] z, input logic [23:0] rgb);
      req_type r;
      r.cmd = c;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.cell_rgb = rgb;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_push <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_push <= 1;
      req_data <= r;
      forever begin
         @(negedge clock);
         if (!req_full) break;
      end
      @(posedge clock);
      if (c != CMD_NONE) items++;
   endtask

   task automatic send_pulls(input int count);
      repeat (count) send(CMD_PULL, 16'($urandom), 16'($urandom), 16'($urandom),
                          24'($urandom));
   endtask

   task automatic settle();
      req_push <= 0;
      forever begin
         @(negedge clock);
         if (outstanding == 0) break;
      end
      repeat (32) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index r, input logic [31:0] v);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(input reg_index r);
      case (r)
         REG_RASTER_MODE:  return $urandom_range(0, 3);
         REG_FORWARD_AXIS: return $urandom_range(0, 7);
         REG_UP_AXIS:      return $urandom_range(0, 7);
         REG_PIX_PER_CELL: return $urandom_range(0, 31);
         REG_MAX_PIXELS: begin
            case ($urandom_range(0, 3))
               0: return $urandom_range(0, 300);
               1: return 32'h1000000;
               default: return $urandom & 32'h1ffffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int i, k, cnt;
      logic [15:0] bx, by, bz;
      bit wide;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // no image yet, then finish with an empty list
      send(CMD_PULL, 16'h0, 16'h0, 16'h0, 24'h0);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      // extreme coordinates blow the pixel limit
      send(CMD_ADD, 16'h7fff, 16'h8000, 16'h0000, 24'hffffff);
      send(CMD_ADD, 16'h8000, 16'h7fff, 16'hffff, 24'h000000);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      // 100 cells wide fits the pixel limit but not the grid
      send(CMD_ADD, 16'd0, 16'd0, 16'd0, 24'h123456);
      send(CMD_ADD, 16'd0, 16'd99, 16'd0, 24'h654321);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      settle();
      write_reg(REG_PIX_PER_CELL, 32'd0);
      write_reg(REG_RASTER_MODE, 32'd3);
      write_reg(REG_BACKGROUND, 32'h0a0b0c0d);
      // equal depths keep the first cell, nearer depth wins the other column
      send(CMD_ADD, 16'd0, 16'd0, 16'd0, 24'hff0000);
      send(CMD_ADD, 16'd0, 16'd0, 16'd0, 24'h00ff00);
      send(CMD_ADD, 16'd5, 16'd1, 16'd0, 24'h0000ff);
      send(CMD_ADD, 16'd2, 16'd1, 16'd0, 24'hffff00);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      send_pulls(3);
      // long receiver hold-off while pulls keep coming
      hold_req = 1;
      send_pulls(12);
      settle();
      write_reg(REG_RASTER_MODE, 32'(MODE_SILHOUETTE));
      write_reg(REG_FORWARD_AXIS, 32'd7);
      write_reg(REG_UP_AXIS, 32'd1);
      write_reg(REG_PIX_PER_CELL, 32'd17);
      write_reg(REG_FOREGROUND, 32'h11223344);
      send(CMD_ADD, 16'd3, 16'd4, 16'd5, 24'habcdef);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      send_pulls(3);
      settle();
      write_reg(REG_RASTER_MODE, 32'(MODE_THICKNESS));
      write_reg(REG_FORWARD_AXIS, 32'd0);
      write_reg(REG_UP_AXIS, 32'd4);
      write_reg(REG_PIX_PER_CELL, 32'd16);
      send(CMD_ADD, 16'd0, 16'd0, 16'd0, 24'h0);
      send(CMD_ADD, 16'd1, 16'd0, 16'd0, 24'h0);
      send(CMD_ADD, 16'd2, 16'd0, 16'd0, 24'h0);
      send(CMD_ADD, 16'd0, 16'd1, 16'd0, 24'h0);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      send_pulls(4);
      settle();
      write_reg(REG_PIX_PER_CELL, 32'd1);
      write_reg(REG_MAX_PIXELS, 32'd0);
      send(CMD_ADD, 16'd1, 16'd1, 16'd1, 24'h0);
      send(CMD_FINISH, 16'h0, 16'h0, 16'h0, 24'h0);
      // a failed finish drops the earlier image
      send_pulls(1);
      settle();
      write_reg(REG_MAX_PIXELS, 32'h1000000);

      while (items < 950) begin
         calm = (items > 800);
         if ($urandom_range(0, 3) == 0) begin
            settle();
            if ($urandom_range(0, 3) == 0) begin
               for (i = 0; i < 7; i++) write_reg(reg_index'(i), pick_value(reg_index'(i)));
            end else begin
               repeat ($urandom_range(1, 3)) begin
                  k = $urandom_range(0, 6);
                  write_reg(reg_index'(k), pick_value(reg_index'(k)));
               end
            end
         end
         cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
         wide = ($urandom_range(0, 7) == 0);
         bx = 16'($urandom);
         by = 16'($urandom);
         bz = 16'($urandom);
         for (i = 0; i < cnt; i++) begin
            if ($urandom_range(0, 9) == 0)
               send(CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
            if (wide)
               send(CMD_ADD, 16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
            else
               send(CMD_ADD, bx + 16'($urandom_range(0, 7)), by + 16'($urandom_range(0, 7)),
                    bz + 16'($urandom_range(0, 7)), 24'($urandom));
         end
         send(CMD_FINISH, 16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
         send_pulls(($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 30));
      end

      settle();
      repeat (64) @(posedge clock);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/vor_pkg.sv
rtl/core/vor_ram.sv
rtl/core/vor_front.sv
rtl/core/vor_back.sv
rtl/core/voxel_orthographic_rasterizer_unit.sv
tb/vor_csr_pkg.sv
tb/vor_checker.sv
tb/voxel_orthographic_rasterizer_unit_tb.sv
